// ===== rtl/best_fit_block_allocator_macros.svh =====
// assertion helpers used by the checker of this block
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BFBA_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BFBA_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfba_pkg.sv =====
package bfba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  localparam int INDEX_W     = 4;
  localparam int ITEM_SIZE_W = 16;
  localparam int LEFTOVER_W  = 16;
  localparam int COUNT_W     = 5;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [INDEX_W-1:0]     load_index;
    logic [ITEM_SIZE_W-1:0] item_size;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_W-1:0]    granted_index;
    logic [LEFTOVER_W-1:0] leftover;
  } res_t;

  typedef struct packed {
    logic fit;
    logic better;
  } cmp_flags_t;

endpackage

// ===== rtl/bfba_cmp.sv =====
module bfba_cmp
  import bfba_pkg::*;
#(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic [SIZE_WIDTH-1:0] cand_size,
  input  logic [SIZE_WIDTH-1:0] req_size,
  input  logic [SIZE_WIDTH-1:0] best_left,
  input  logic                  have,
  output logic [SIZE_WIDTH-1:0] left,
  output cmp_flags_t            flags
);

  // one subtract and two compares, reused for every entry of the scan
  always_comb begin
    left         = cand_size - req_size;
    flags.fit    = (cand_size >= req_size);
    flags.better = flags.fit && (!have || (left < best_left));
  end

endmodule

// ===== rtl/best_fit_block_allocator.sv =====
// allocate request: the scan covers min(block_count, NUM_BLOCKS) entries between acceptance
// and the result strobe; the size memory is read one entry per cycle.
// busy is high from an allocate until its strobe shows, and the next request can be taken
// in the strobe cycle. load request: no result, no busy.
// rst_n is synchronous, active low: clears marks, block_count and the sequencer;
// block sizes are undefined until loaded. results cannot be stalled.
module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  req_t               in_req,
  output logic               out_strobe,
  output res_t               out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LIM_W = ($clog2(NUM_BLOCKS + 1) > COUNT_W) ? $clog2(NUM_BLOCKS + 1) : COUNT_W;
  localparam int SZX_W = (SIZE_WIDTH > ITEM_SIZE_W) ? SIZE_WIDTH : ITEM_SIZE_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                  state_r;
  logic [COUNT_W-1:0]      block_count_r;
  logic [SIZE_WIDTH-1:0]   req_size_r;
  logic [LIM_W-1:0]        limit_r;
  logic [LIM_W-1:0]        cnt_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [SIZE_WIDTH-1:0]   rd_data_r;
  logic                    have_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [SIZE_WIDTH-1:0]   best_left_r;
  logic [NUM_BLOCKS-1:0]   mark_r;
  logic                    out_strobe_r;
  res_t                    out_res_r;

  logic [SIZE_WIDTH-1:0]   size_mem [NUM_BLOCKS];

  logic                    accept;
  logic                    is_load;
  logic                    is_alloc;
  logic [LIM_W-1:0]        idx_ext;
  logic                    load_ok;
  logic [IDX_W-1:0]        waddr;
  logic [SZX_W-1:0]        size_ext;
  logic [SIZE_WIDTH-1:0]   in_size;
  logic [LIM_W-1:0]        count_ext;
  logic [LIM_W-1:0]        limit_nxt;
  logic                    issue;
  logic                    finish;
  logic                    take;
  logic [SIZE_WIDTH-1:0]   cmp_left;
  cmp_flags_t              cmp_flags;
  logic [LIM_W-1:0]        gidx_ext;
  logic [SZX_W-1:0]        left_ext;

  always_comb begin
    accept    = start && !busy;
    is_load   = accept && (in_req.opcode == OP_LOAD);
    is_alloc  = accept && (in_req.opcode == OP_ALLOC);
    idx_ext   = LIM_W'(in_req.load_index);
    load_ok   = (idx_ext < LIM_W'(NUM_BLOCKS));
    waddr     = idx_ext[IDX_W-1:0];
    size_ext  = SZX_W'(in_req.item_size);
    in_size   = size_ext[SIZE_WIDTH-1:0];
    count_ext = LIM_W'(block_count_r);
    limit_nxt = (count_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : count_ext;
    // read one entry per cycle, then let the last compare settle
    issue     = (state_r == S_SCAN) && (cnt_r < limit_r);
    finish    = (state_r == S_SCAN) && !issue && !rd_vld_r;
    take      = rd_vld_r && !mark_r[rd_idx_r] && cmp_flags.better;
    gidx_ext  = LIM_W'(best_idx_r);
    left_ext  = SZX_W'(best_left_r);
  end

  bfba_cmp #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_cmp (
    .cand_size (rd_data_r),
    .req_size  (req_size_r),
    .best_left (best_left_r),
    .have      (have_r),
    .left      (cmp_left),
    .flags     (cmp_flags)
  );

  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      size_mem[waddr] <= in_size;
    end
    if (issue) begin
      rd_data_r <= size_mem[cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_count_r <= '0;
      mark_r        <= '0;
      rd_vld_r      <= 1'b0;
      have_r        <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      out_strobe_r <= finish;
      rd_vld_r     <= issue;
      if (cfg_valid && cfg_ready) begin
        block_count_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (is_load && load_ok) begin
            mark_r[waddr] <= 1'b0;
          end
          if (is_alloc) begin
            req_size_r  <= in_size;
            limit_r     <= limit_nxt;
            cnt_r       <= '0;
            have_r      <= 1'b0;
            best_idx_r  <= '0;
            best_left_r <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt_r    <= cnt_r + LIM_W'(1);
            rd_idx_r <= cnt_r[IDX_W-1:0];
          end
          if (take) begin
            have_r      <= 1'b1;
            best_left_r <= cmp_left;
            best_idx_r  <= rd_idx_r;
          end
          if (finish) begin
            out_res_r.found         <= have_r;
            out_res_r.granted_index <= gidx_ext[INDEX_W-1:0];
            out_res_r.leftover      <= left_ext[LEFTOVER_W-1:0];
            if (have_r) begin
              mark_r[best_idx_r] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = !busy;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ===== rtl/bfba_chk.sv =====
`include "best_fit_block_allocator_macros.svh"

module bfba_chk
  import bfba_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input req_t               in_req,
  input logic               out_strobe,
  input res_t               out_res,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [COUNT_W-1:0] cfg_data
);

  logic alloc_acc;
  logic load_acc;
  logic cfg_acc;

  assign alloc_acc = start && !busy && (in_req.opcode == OP_ALLOC);
  assign load_acc  = start && !busy && (in_req.opcode == OP_LOAD);
  assign cfg_acc   = cfg_valid && cfg_ready && (cfg_data == cfg_data);

  `BFBA_AST_IMP(a_res_after_busy, out_strobe, $past(busy), "result without a pending allocate")
  `BFBA_AST_IMP(a_miss_zero, out_strobe && !out_res.found,
    (out_res.granted_index == '0) && (out_res.leftover == '0), "miss with nonzero fields")
  `BFBA_AST_NXT(a_load_no_res, load_acc, !busy && !out_strobe, "load request gave a result")
  `BFBA_AST_NXT(a_alloc_busy, alloc_acc, busy && !out_strobe, "allocate not held busy")
  `BFBA_AST_IMP(a_cfg_idle, cfg_acc, !busy, "config write while busy")

endmodule

bind best_fit_block_allocator bfba_chk u_bfba_chk (.*);
